>>> hw/rtl/u8l1_pkg.sv
// Shared types, constants and helpers for the UTF-8 check / Latin-1 transcoder.
`timescale 1ns / 1ps
package u8l1_pkg;

    // Default depth of the queue between the front and back parts.
    localparam int unsigned U8L1_QDEPTH = 4;

    localparam logic [7:0] C_HIGH_BIT  = 8'h80;
    localparam logic [7:0] C_MASK_CONT = 8'hC0;
    localparam logic [7:0] C_MASK_LEAD3 = 8'hE0;
    localparam logic [7:0] C_MASK_LEAD4 = 8'hF0;
    localparam logic [7:0] C_MASK_LEAD5 = 8'hF8;
    localparam logic [7:0] C_LOW6      = 8'h3F;

    // One classified byte waiting for the back part.
    typedef struct packed {
        logic [7:0] byte_val;  // raw input byte
        logic       last;      // final byte of the body
        logic       verdict;   // body valid (only meaningful when last)
    } t_entry;

    // Queue status seen by the back part.
    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_q_status;

    function automatic logic is_high(input logic [7:0] c);
        return c[7];
    endfunction

    // First byte of the two-byte UTF-8 form of a Latin-1 byte.
    function automatic logic [7:0] lead_of(input logic [7:0] c);
        return C_MASK_CONT | {6'd0, c[7:6]};
    endfunction

    // Second byte of the two-byte UTF-8 form of a Latin-1 byte.
    function automatic logic [7:0] tail_of(input logic [7:0] c);
        return C_HIGH_BIT | (c & C_LOW6);
    endfunction

endpackage

>>> hw/rtl/u8l1_front.sv
// Front part: takes input words, runs the UTF-8 check and classifies each byte.
`timescale 1ns / 1ps
module u8l1_front
    import u8l1_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_q_full,
    input  logic [7:0] i_in_byte,
    input  logic   i_body_last,
    output logic   o_in_stall,
    output logic   o_push,
    output t_entry o_entry
);

    logic [1:0] r_pend;
    logic       r_inv;
    logic [1:0] n_pend;
    logic       n_inv;
    logic [1:0] chk_pend;
    logic       chk_inv;
    logic       accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    // Checker step for this byte
    always_comb begin
        chk_pend = r_pend;
        chk_inv  = r_inv;
        if (r_pend != 2'd0) begin
            if ((i_in_byte & C_MASK_CONT) == C_HIGH_BIT) begin
                chk_pend = r_pend - 2'd1;
            end else begin
                chk_inv  = 1'b1;
                chk_pend = 2'd0;
            end
        end else if (is_high(i_in_byte)) begin
            priority if ((i_in_byte & C_MASK_LEAD3) == C_MASK_CONT) begin
                chk_pend = 2'd1;
            end else if ((i_in_byte & C_MASK_LEAD4) == C_MASK_LEAD3) begin
                chk_pend = 2'd2;
            end else if ((i_in_byte & C_MASK_LEAD5) == C_MASK_LEAD4) begin
                chk_pend = 2'd3;
            end else begin
                chk_inv = 1'b1;
            end
        end
    end

    always_comb begin
        o_entry.byte_val = i_in_byte;
        o_entry.last     = i_body_last;
        o_entry.verdict  = i_body_last && !chk_inv && (chk_pend == 2'd0);
        n_pend = r_pend;
        n_inv  = r_inv;
        if (accept) begin
            n_pend = i_body_last ? 2'd0 : chk_pend;
            n_inv  = i_body_last ? 1'b0 : chk_inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_inv  <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_inv  <= n_inv;
        end
    end

endmodule

>>> hw/rtl/u8l1_queue.sv
// Small register queue between the front and back parts.
`timescale 1ns / 1ps
module u8l1_queue
    import u8l1_pkg::*;
#(
    parameter int unsigned P_DEPTH = U8L1_QDEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output logic      o_full,
    output t_q_status o_status
);

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_entry        r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full          = (r_count == CW'(P_DEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.head   = r_mem[r_rd_ptr];
    assign do_push         = i_push && !o_full;
    assign do_pop          = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> hw/rtl/u8l1_back.sv
// Back part: expands queued bytes into one or two output words.
`timescale 1ns / 1ps
module u8l1_back
    import u8l1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_status,
    input  logic       i_out_stall,
    output logic       o_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_body_end,
    output logic       o_body_valid
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_end;
    logic       r_bvalid;
    logic       r_second;   // lead byte already sent for the head entry

    logic       n_valid;
    logic [7:0] n_byte;
    logic       n_run_last;
    logic       n_end;
    logic       n_bvalid;
    logic       n_second;
    logic       out_free;
    logic       fin;

    assign out_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid    = r_valid;
        n_byte     = r_byte;
        n_run_last = r_run_last;
        n_end      = r_end;
        n_bvalid   = r_bvalid;
        n_second   = r_second;
        o_pop      = 1'b0;
        fin        = 1'b0;
        if (out_free) begin
            n_valid = !i_status.empty;
            if (!i_status.empty) begin
                if (!is_high(i_status.head.byte_val)) begin
                    n_byte = i_status.head.byte_val;
                    fin    = 1'b1;
                end else if (!r_second) begin
                    n_byte   = lead_of(i_status.head.byte_val);
                    n_second = 1'b1;
                end else begin
                    n_byte   = tail_of(i_status.head.byte_val);
                    n_second = 1'b0;
                    fin      = 1'b1;
                end
                o_pop      = fin;
                n_run_last = fin;
                n_end      = fin && i_status.head.last;
                n_bvalid   = fin && i_status.head.last && i_status.head.verdict;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_run_last <= n_run_last;
        r_end      <= n_end;
        r_bvalid   <= n_bvalid;
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_run_last;
    assign o_body_end   = r_end;
    assign o_body_valid = r_bvalid;

endmodule

>>> hw/rtl/utf8_check_latin1_transcode.sv
// Top level of the UTF-8 checker with Latin-1 to UTF-8 transcoding.
`timescale 1ns / 1ps
// Usage:
//  Input channel (i_in_valid / o_in_stall) takes one body byte per word, with
//  i_body_last high on the final byte of a body. Output channel (o_out_valid /
//  i_out_stall) gives the transcoded bytes: one word for a byte below 0x80,
//  two words otherwise. o_run_last marks the last word of each input byte,
//  o_body_end the last word of a body, where o_body_valid carries the verdict.
//  The front checks each byte as it is taken and stores it in a small queue;
//  the back drains the queue into a registered output stage.
//  Path: a byte taken is written into the queue, then into the output register.
//  Throughput: one output word per cycle while i_out_stall is low; the single
//  output register sets that limit. The queue lets input words keep coming
//  while a two-word byte is being expanded.
//  Stall: an output word holds while i_out_stall is high; once the queue fills,
//  o_in_stall rises and input is held off.
//  Reset (synchronous, active low) empties the queue and output stage and
//  clears the checker state, so the next byte starts a fresh body.
module utf8_check_latin1_transcode
    import u8l1_pkg::*;
#(
    parameter int unsigned P_QDEPTH = U8L1_QDEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_body_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_body_end,
    output logic       o_body_valid
);

    logic      q_full;
    logic      push;
    logic      pop;
    t_entry    entry;
    t_q_status q_status;

    u8l1_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_q_full    (q_full),
        .i_in_byte   (i_in_byte),
        .i_body_last (i_body_last),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_entry     (entry)
    );

    u8l1_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_full   (q_full),
        .o_status (q_status)
    );

    u8l1_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_status     (q_status),
        .i_out_stall  (i_out_stall),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_body_end   (o_body_end),
        .o_body_valid (o_body_valid)
    );

endmodule

>>> verif/utf8_check_latin1_transcode_tb.sv
// Testbench for the UTF-8 checker with Latin-1 to UTF-8 transcoding.
`timescale 1ns / 1ps
//
// Bodies of bytes are pushed through the input channel.
// - A short directed part comes first: ASCII extremes, stray high bytes, lead bytes of
//   every length, a truncated body, a sticky error and the 0xF8..0xFF range.
// - Then random bodies: mostly well-formed UTF-8 with random content, the rest noise,
//   truncated or corrupted.
// A tracker class holds the checker state and the queue of expected output words.
// Each accepted output word is compared with the oldest expected one.
// The sender works in bursts with gaps between them.
// The receiver stalls in modes that change over the run.
module utf8_check_latin1_transcode_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned BYTE_TARGET = 950;   // directed plus random
    localparam int unsigned REPORT_MAX  = 10;

    // One word on the output channel.
    typedef struct packed {
        logic [7:0] code;
        logic       run_last;
        logic       body_end;
        logic       body_valid;
    } t_out_word;

    // Checker state plus the words still owed by the block.
    class utf8_word_tracker;
        t_out_word  expected_words[$];
        bit [1:0]   conts_left;   // continuation bytes still owed
        bit         body_bad;     // sticky until the end of the body
        int         mismatches;
        int         strays;

        function void take_byte(input logic [7:0] c, input logic last);
            t_out_word w;
            logic      verdict;
            verdict = 1'b0;
            if (conts_left != 2'd0) begin
                if (c[7:6] == 2'b10) begin
                    conts_left = conts_left - 2'd1;
                end else begin
                    body_bad   = 1'b1;
                    conts_left = 2'd0;
                end
            end else if (c[7]) begin
                if (c[7:5] == 3'b110) begin
                    conts_left = 2'd1;
                end else if (c[7:4] == 4'b1110) begin
                    conts_left = 2'd2;
                end else if (c[7:3] == 5'b11110) begin
                    conts_left = 2'd3;
                end else begin
                    body_bad = 1'b1;
                end
            end
            if (last) begin
                verdict    = !body_bad && (conts_left == 2'd0);
                body_bad   = 1'b0;
                conts_left = 2'd0;
            end
            if (!c[7]) begin
                w = '{code: c, run_last: 1'b1, body_end: last, body_valid: verdict};
                expected_words.push_back(w);
            end else begin
                w = '{code: {6'b110000, c[7:6]}, run_last: 1'b0, body_end: 1'b0,
                      body_valid: 1'b0};
                expected_words.push_back(w);
                w = '{code: {2'b10, c[5:0]}, run_last: 1'b1, body_end: last,
                      body_valid: verdict};
                expected_words.push_back(w);
            end
        endfunction

        function void check_word(input t_out_word got);
            t_out_word want;
            if (expected_words.size() == 0) begin
                strays++;
                if (strays + mismatches <= REPORT_MAX)
                    $display("unexpected word: byte %02h run_last %0d end %0d valid %0d",
                             got.code, got.run_last, got.body_end, got.body_valid);
            end else begin
                want = expected_words.pop_front();
                if (got.code != want.code || got.run_last != want.run_last ||
                    got.body_end != want.body_end || got.body_valid != want.body_valid) begin
                    mismatches++;
                    if (strays + mismatches <= REPORT_MAX)
                        $display("mismatch: exp %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                                 want.code, want.run_last, want.body_end, want.body_valid,
                                 got.code, got.run_last, got.body_end, got.body_valid);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int failures();
            return mismatches + strays + expected_words.size();
        endfunction
    endclass

    // Block ports; every input that the bench drives starts at a known value.
    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_body_last  = 1'b0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_body_end;
    logic       o_body_valid;

    utf8_word_tracker tracker = new;

    logic [7:0]  body_bytes[$];     // body being composed for sending
    int unsigned bytes_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;

    utf8_check_latin1_transcode dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_body_last  (i_body_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_body_end   (o_body_end),
        .o_body_valid (o_body_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output monitor. Outputs are sampled as they stood before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_word('{code: o_out_byte, run_last: o_run_last,
                                 body_end: o_body_end, body_valid: o_body_valid});
    end

    // Receiver stall pattern. The mode is redrawn at random whenever its countdown runs out:
    // 0 never stalls, 1 stalls lightly, 2 stalls heavily, 3 takes long stalls now and then.
    int unsigned stall_mode  = 0;
    int unsigned mode_left   = 200;
    int unsigned stall_run   = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(3, 0);
            mode_left  = $urandom_range(300, 60);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(3, 0) == 0);
            2: i_out_stall <= ($urandom_range(3, 0) != 0);
            default: begin
                if (stall_run != 0) begin
                    stall_run--;
                    i_out_stall <= 1'b1;
                end else if ($urandom_range(9, 0) == 0) begin
                    stall_run = $urandom_range(15, 4);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        endcase
    end

    // Offers one word and returns at the edge that takes it.
    // A gap only comes when a burst runs out; within a burst valid stays high.
    task automatic push_byte(input logic [7:0] c, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(12, 1);
        end
        i_in_valid  <= 1'b1;
        i_in_byte   <= c;
        i_body_last <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_byte(c, last);
        bytes_sent++;
        burst_left--;
    endtask

    // Holds the input off until every owed word has come out.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_body();
        foreach (body_bytes[k])
            push_byte(body_bytes[k], k == body_bytes.size() - 1);
    endtask

    // Appends one well-formed character: ASCII or a 2, 3 or 4 byte sequence.
    task automatic add_char();
        int unsigned conts;
        conts = $urandom_range(3, 0);
        case (conts)
            0: body_bytes.push_back(8'($urandom_range(8'h7F, 8'h00)));
            1: body_bytes.push_back(8'($urandom_range(8'hDF, 8'hC0)));
            2: body_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
            default: body_bytes.push_back(8'($urandom_range(8'hF7, 8'hF0)));
        endcase
        repeat (conts) body_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
    endtask

    // Random body: mostly well-formed, otherwise noise, truncated or corrupted.
    task automatic compose_body();
        int unsigned flavour;
        int unsigned spot;
        body_bytes.delete();
        flavour = $urandom_range(19, 0);
        if (flavour < 3) begin
            repeat ($urandom_range(8, 1)) body_bytes.push_back(8'($urandom_range(255, 0)));
        end else begin
            repeat ($urandom_range(10, 1)) add_char();
            if (flavour == 3 && body_bytes.size() > 1) begin
                body_bytes.pop_back();
            end else if (flavour == 4) begin
                spot = $urandom_range(body_bytes.size() - 1, 0);
                body_bytes[spot] = 8'($urandom_range(255, 0));
            end
        end
    endtask

    // Directed words, {last, byte}: ASCII extremes, stray continuation, 0xFF, lead bytes
    // of each length with full sequences, a truncated body, a sticky error after a bad
    // continuation, 0xF8 in the middle, and the lowest and highest two-byte leads.
    localparam logic [8:0] OPENING_WORDS [25] = '{
        9'h100, 9'h17F, 9'h180, 9'h1FF,
        9'h0C3, 9'h1A9,
        9'h0E2, 9'h082, 9'h1AC,
        9'h0F0, 9'h09F, 9'h098, 9'h180,
        9'h1C3,
        9'h0E2, 9'h041, 9'h0C3, 9'h1A9,
        9'h041, 9'h0F8, 9'h142,
        9'h0C0, 9'h080, 9'h0DF, 9'h1BF
    };

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING_WORDS[k])
            push_byte(OPENING_WORDS[k][7:0], OPENING_WORDS[k][8]);
        // Full drain once so the block runs empty before the random part.
        drain_block();

        while (bytes_sent < BYTE_TARGET) begin
            compose_body();
            send_body();
            if ($urandom_range(29, 0) == 0)
                drain_block();
        end

        drain_block();
        repeat (20) @(posedge i_clk);
        if (tracker.failures() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/u8l1_pkg.sv
hw/rtl/u8l1_front.sv
hw/rtl/u8l1_queue.sv
hw/rtl/u8l1_back.sv
hw/rtl/utf8_check_latin1_transcode.sv
verif/utf8_check_latin1_transcode_tb.sv
